// ===== rtl/dst_pkg.sv =====
package dst_pkg;

    localparam int SEP_MAX  = 8;
    localparam int BYTE_W   = 8;
    localparam int SEP_W    = SEP_MAX * BYTE_W;
    localparam int CNT_W    = $clog2(SEP_MAX + 1);
    localparam int IDX_W    = $clog2(SEP_MAX);
    localparam int LEN_W    = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SEP_BYTES  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_LENGTH = 1'd1;

    localparam logic [SEP_W-1:0] SEP_BYTES_RST  = 64'd32;
    localparam logic [LEN_W-1:0] SEP_LENGTH_RST = 4'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RESOLVE,
        S_FLUSH
    } t_state;

    // Per-cycle command to the window chain
    typedef struct packed {
        logic              clear;
        logic              pop;
        logic              load;
        logic [BYTE_W-1:0] load_byte;
    } t_win_ctrl;

    // Clamp the separator length register to 1..SEP_MAX
    function automatic logic [CNT_W-1:0] eff_length(input logic [LEN_W-1:0] len);
        logic [CNT_W-1:0] n;
        if (len == '0) begin
            n = CNT_W'(1);
        end else if (len > LEN_W'(SEP_MAX)) begin
            n = CNT_W'(SEP_MAX);
        end else begin
            n = CNT_W'(len);
        end
        return n;
    endfunction

endpackage

// ===== rtl/dst_if.sv =====
interface dst_in_if;
    import dst_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface dst_out_if;
    import dst_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              is_boundary;
    logic              run_last;

    modport source (output valid, output out_byte, output is_boundary, output run_last,
                    input ready);
    modport sink   (input valid, input out_byte, input is_boundary, input run_last,
                    output ready);
endinterface

// ===== rtl/dst_cell.sv =====
module dst_cell
    import dst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_win_ctrl         i_ctrl,
    input  logic              i_load_sel,
    input  logic [BYTE_W-1:0] i_next_byte,
    input  logic [BYTE_W-1:0] i_sep_byte,
    input  logic              i_use,
    input  logic              i_match,
    output logic [BYTE_W-1:0] o_byte,
    output logic              o_match
);

    logic [BYTE_W-1:0] r_byte;
    logic [BYTE_W-1:0] n_byte;

    always_comb begin
        n_byte = r_byte;
        if (i_ctrl.clear) begin
            n_byte = '0;
        end else if (i_ctrl.pop) begin
            n_byte = i_next_byte;
        end else if (i_ctrl.load && i_load_sel) begin
            n_byte = i_ctrl.load_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else begin
            r_byte <= n_byte;
        end
    end

    assign o_byte  = r_byte;
    // Unused positions pass the match through
    assign o_match = i_match && (!i_use || (r_byte == i_sep_byte));

endmodule

// ===== rtl/dst_window.sv =====
module dst_window
    import dst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_win_ctrl         i_ctrl,
    input  logic [IDX_W-1:0]  i_load_idx,
    input  logic [SEP_W-1:0]  i_sep_bytes,
    input  logic [SEP_MAX-1:0] i_use,
    output logic [BYTE_W-1:0] o_head,
    output logic              o_match
);

    logic [BYTE_W-1:0] w_byte  [SEP_MAX+1];
    logic              w_match [SEP_MAX+1];

    assign w_byte[SEP_MAX] = '0;
    assign w_match[0]      = 1'b1;

    for (genvar g = 0; g < SEP_MAX; g++) begin : g_cell
        dst_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (i_ctrl),
            .i_load_sel  (i_load_idx == IDX_W'(g)),
            .i_next_byte (w_byte[g+1]),
            .i_sep_byte  (i_sep_bytes[g*BYTE_W +: BYTE_W]),
            .i_use       (i_use[g]),
            .i_match     (w_match[g]),
            .o_byte      (w_byte[g]),
            .o_match     (w_match[g+1])
        );
    end

    assign o_head  = w_byte[0];
    assign o_match = w_match[SEP_MAX];

endmodule

// ===== rtl/delimiter_string_tokenizer.sv =====
// An accepted byte moves the control to the resolve state, which writes its result into
// the output register. A byte is taken only in the idle state; each resolve step emits one
// result or none. End of string, unless a match just emptied the window, drains leftover
// bytes one per cycle and then takes a closing step that carries the boundary of an open
// token. Resolve and flush steps wait while the output register holds a stalled beat.
// Reset (synchronous, active low) empties the window, closes the token, loads a space.
module delimiter_string_tokenizer
    import dst_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SEP_W-1:0]     i_cfg_data,
    dst_in_if.sink               i_in,
    dst_out_if.source            o_out
);

    // Configuration registers
    logic [SEP_W-1:0] r_sep_bytes;
    logic [LEN_W-1:0] r_sep_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep_bytes <= SEP_BYTES_RST;
            r_sep_len   <= SEP_LENGTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SEP_BYTES:  r_sep_bytes <= i_cfg_data;
                CFG_SEP_LENGTH: r_sep_len   <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective length and the per-cell compare enables
    logic [CNT_W-1:0]   w_len;
    logic [SEP_MAX-1:0] w_use;

    always_comb begin
        w_len = eff_length(r_sep_len);
        for (int i = 0; i < SEP_MAX; i++) begin
            w_use[i] = (CNT_W'(i) < w_len);
        end
    end

    // Control state
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_open, n_open;
    logic             r_last;

    // Output register
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_bnd;
    logic              r_out_run_last;

    logic              w_in_beat;
    logic              w_free;
    logic              w_full_win;
    logic              w_match;
    logic [BYTE_W-1:0] w_head;
    t_win_ctrl         w_ctrl;

    logic              w_emit;
    logic [BYTE_W-1:0] w_emit_byte;
    logic              w_emit_bnd;
    logic              w_emit_last;

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_in_beat   = i_in.valid && i_in.ready;
    // The output register can take a new result this cycle
    assign w_free      = !r_out_valid || o_out.ready;
    assign w_full_win  = (r_count >= w_len);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_beat) begin
                    n_state = S_RESOLVE;
                end
            end
            S_RESOLVE: begin
                if (w_free) begin
                    if (w_full_win) begin
                        if (w_match) begin
                            // A match empties the window and closes the token
                            n_state = S_IDLE;
                        end else if (r_count > w_len) begin
                            n_state = S_RESOLVE;
                        end else begin
                            n_state = r_last ? S_FLUSH : S_IDLE;
                        end
                    end else begin
                        n_state = r_last ? S_FLUSH : S_IDLE;
                    end
                end
            end
            S_FLUSH: begin
                if (w_free && (r_count == '0)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Window commands and results
    always_comb begin
        w_ctrl           = '0;
        w_ctrl.load_byte = i_in.in_byte;
        n_count          = r_count;
        n_open           = r_open;
        w_emit           = 1'b0;
        w_emit_byte      = '0;
        w_emit_bnd       = 1'b0;
        w_emit_last      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_beat) begin
                    // Append at the first free cell
                    w_ctrl.load = 1'b1;
                    n_count     = r_count + CNT_W'(1);
                end
            end
            S_RESOLVE: begin
                if (w_free && w_full_win) begin
                    if (w_match) begin
                        // Drop the separator; mark the boundary only for a nonempty token
                        w_ctrl.clear = 1'b1;
                        n_count      = '0;
                        n_open       = 1'b0;
                        w_emit       = r_open;
                        w_emit_bnd   = 1'b1;
                        w_emit_last  = 1'b1;
                    end else begin
                        // Advance the window: the oldest byte is token data
                        w_ctrl.pop  = 1'b1;
                        n_count     = r_count - CNT_W'(1);
                        n_open      = 1'b1;
                        w_emit      = 1'b1;
                        w_emit_byte = w_head;
                        w_emit_last = !r_last && (r_count == w_len);
                    end
                end
            end
            S_FLUSH: begin
                if (w_free) begin
                    if (r_count != '0) begin
                        // Drain leftover bytes; a boundary always follows
                        w_ctrl.pop  = 1'b1;
                        n_count     = r_count - CNT_W'(1);
                        n_open      = 1'b1;
                        w_emit      = 1'b1;
                        w_emit_byte = w_head;
                    end else begin
                        n_open      = 1'b0;
                        w_emit      = r_open;
                        w_emit_bnd  = 1'b1;
                        w_emit_last = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_open      <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_open  <= n_open;
            if (w_in_beat) begin
                r_last <= i_in.end_of_string;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the payload until the sink takes the beat
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_byte     <= w_emit_byte;
            r_out_bnd      <= w_emit_bnd;
            r_out_run_last <= w_emit_last;
        end
    end

    dst_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_load_idx  (r_count[IDX_W-1:0]),
        .i_sep_bytes (r_sep_bytes),
        .i_use       (w_use),
        .o_head      (w_head),
        .o_match     (w_match)
    );

    assign o_out.valid       = r_out_valid;
    assign o_out.out_byte    = r_out_byte;
    assign o_out.is_boundary = r_out_bnd;
    assign o_out.run_last    = r_out_run_last;

endmodule
